// ===== hdl/gnia_pkg.sv =====
// ----------------------------------------------------------------------------
// gnia_pkg
// Shared codes and pipeline control type for the graph node integer ALU.
// ----------------------------------------------------------------------------
package gnia_pkg;

   localparam logic [4:0] OP_ABS        = 5'd16;
   localparam logic [4:0] OP_MEAN       = 5'd17;
   localparam logic [4:0] OP_INPUT_NODE = 5'd18;

   localparam logic [3:0] GRP_ADD = 4'd0;
   localparam logic [3:0] GRP_SUB = 4'd1;
   localparam logic [3:0] GRP_MUL = 4'd2;
   localparam logic [3:0] GRP_DIV = 4'd3;
   localparam logic [3:0] GRP_MOD = 4'd4;
   localparam logic [3:0] GRP_MAX = 4'd5;
   localparam logic [3:0] GRP_MIN = 4'd6;
   localparam logic [3:0] GRP_POW = 4'd7;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DIV_ZERO = 2'd1;
   localparam logic [1:0] ST_BAD_OP   = 2'd2;

   localparam logic [1:0] KIND_SIMPLE = 2'd0;
   localparam logic [1:0] KIND_DIV    = 2'd1;
   localparam logic [1:0] KIND_MOD    = 2'd2;
   localparam logic [1:0] KIND_POW    = 2'd3;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic [1:0] status;
      logic       neg_q;
      logic       neg_r;
   } ctrl_type;

endpackage

// ===== hdl/gnia_iter.sv =====
// ----------------------------------------------------------------------------
// gnia_iter
// One pipeline stage: one restoring divide step and one square-and-multiply
// step on exponent bit STEP.
// ----------------------------------------------------------------------------
module gnia_iter
   import gnia_pkg::*;
#(
   parameter int W    = 32,
   parameter int STEP = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  ctrl_type       ctrl_in,
   input  logic [W-1:0]   rem_in,
   input  logic [W-1:0]   quo_in,
   input  logic [W-1:0]   dvs_in,
   input  logic [W-1:0]   res_in,
   input  logic [W-1:0]   base_in,
   input  logic [W-1:0]   exp_in,
   output ctrl_type       ctrl_out,
   output logic [W-1:0]   rem_out,
   output logic [W-1:0]   quo_out,
   output logic [W-1:0]   dvs_out,
   output logic [W-1:0]   res_out,
   output logic [W-1:0]   base_out,
   output logic [W-1:0]   exp_out
);

   ctrl_type     ctrl_ff;
   logic [W-1:0] rem_ff, rem_in_nx;
   logic [W-1:0] quo_ff, quo_in_nx;
   logic [W-1:0] dvs_ff;
   logic [W-1:0] res_ff, res_in_nx;
   logic [W-1:0] base_ff, base_in_nx;
   logic [W-1:0] exp_ff;
   logic [W:0]   rem_sh;
   logic         ge;

   always_comb begin
      rem_sh    = {rem_in, quo_in[W-1]};
      ge        = rem_sh >= {1'b0, dvs_in};
      rem_in_nx = ge ? W'(rem_sh - {1'b0, dvs_in}) : W'(rem_sh);
      quo_in_nx = {quo_in[W-2:0], ge};
      res_in_nx = res_in;
      if (ctrl_in.kind == KIND_POW && exp_in[STEP]) begin
         res_in_nx = W'(res_in * base_in);
      end
      base_in_nx = W'(base_in * base_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
      if (advance) begin
         rem_ff  <= rem_in_nx;
         quo_ff  <= quo_in_nx;
         dvs_ff  <= dvs_in;
         res_ff  <= res_in_nx;
         base_ff <= base_in_nx;
         exp_ff  <= exp_in;
      end
   end

   assign ctrl_out = ctrl_ff;
   assign rem_out  = rem_ff;
   assign quo_out  = quo_ff;
   assign dvs_out  = dvs_ff;
   assign res_out  = res_ff;
   assign base_out = base_ff;
   assign exp_out  = exp_ff;

endmodule

// ===== hdl/graph_node_integer_alu.sv =====
// ----------------------------------------------------------------------------
// graph_node_integer_alu
// Evaluates one dataflow-graph node per transfer: arithmetic, divide, modulo,
// max, min, power, absolute value, mean and input node.
//
// Request channel: req_valid with req_action, operands and node constant;
// a transfer happens when req_valid is high and req_stall low.
// Response channel: rsp_valid with rsp_node_value and rsp_status, held
// until a cycle with rsp_stall low.
// Pipeline: one front stage, one stage per quotient bit and exponent bit,
// one output stage. Throughput: one node per cycle while no valid response
// is stalled. The depth is set by the bit-serial divide and
// square-and-multiply chains, one bit per stage.
// A stall of a valid response (rsp_valid and rsp_stall high) freezes the
// whole pipeline and raises req_stall in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the block is empty afterwards.
// Status: 0 ok, 1 divide or modulo by zero (value 0), 2 unknown opcode
// (value 0).
// ----------------------------------------------------------------------------
module graph_node_integer_alu
   import gnia_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [4:0]         req_action,
   input  logic signed [31:0] req_operand_a,
   input  logic signed [31:0] req_operand_b,
   input  logic signed [31:0] req_node_constant,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_node_value,
   output logic [1:0]         rsp_status
);

   localparam int W = DATA_WIDTH;

   logic advance;

   logic signed [W-1:0] a_w, b_w, c_w, x_w;
   logic [W-1:0]        ones_w, one_w;
   logic [W:0]          sum_w;
   logic [W-1:0]        mag_a, mag_x;
   logic [3:0]          grp;
   ctrl_type            ctrl_in_nx;
   logic [W-1:0]        res_in_nx, quo_in_nx, dvs_in_nx, base_in_nx, exp_in_nx;

   ctrl_type     ctrl_s [0:W];
   logic [W-1:0] rem_s  [0:W];
   logic [W-1:0] quo_s  [0:W];
   logic [W-1:0] dvs_s  [0:W];
   logic [W-1:0] res_s  [0:W];
   logic [W-1:0] base_s [0:W];
   logic [W-1:0] exp_s  [0:W];

   logic               rsp_valid_ff;
   logic [W-1:0]       value_ff, value_in;
   logic [1:0]         status_ff;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_comb begin
      a_w    = W'(req_operand_a);
      b_w    = W'(req_operand_b);
      c_w    = W'(req_node_constant);
      x_w    = req_action[0] ? b_w : c_w;
      ones_w = '1;
      one_w  = W'(1);
      mag_a  = a_w[W-1] ? W'(-a_w) : W'(a_w);
      mag_x  = x_w[W-1] ? W'(-x_w) : W'(x_w);
      grp    = req_action[4:1];
      sum_w  = {a_w[W-1], a_w} + {b_w[W-1], b_w};
      if (sum_w[W] && sum_w[0]) begin
         sum_w = sum_w + (W+1)'(1);
      end

      ctrl_in_nx.valid  = req_valid;
      ctrl_in_nx.kind   = KIND_SIMPLE;
      ctrl_in_nx.status = ST_OK;
      ctrl_in_nx.neg_q  = a_w[W-1] ^ x_w[W-1];
      ctrl_in_nx.neg_r  = a_w[W-1];
      res_in_nx  = '0;
      quo_in_nx  = mag_a;
      dvs_in_nx  = mag_x;
      base_in_nx = a_w;
      exp_in_nx  = x_w;

      priority if (req_action > OP_INPUT_NODE) begin
         ctrl_in_nx.status = ST_BAD_OP;
      end else if (req_action == OP_INPUT_NODE) begin
         res_in_nx = c_w;
      end else if (req_action == OP_ABS) begin
         res_in_nx = mag_a;
      end else if (req_action == OP_MEAN) begin
         res_in_nx = sum_w[W:1];
      end else begin
         unique case (grp)
            GRP_ADD: res_in_nx = W'(a_w + x_w);
            GRP_SUB: res_in_nx = W'(a_w - x_w);
            GRP_MUL: res_in_nx = W'(a_w * x_w);
            GRP_DIV, GRP_MOD: begin
               if (x_w == '0) begin
                  ctrl_in_nx.status = ST_DIV_ZERO;
               end else begin
                  ctrl_in_nx.kind = (grp == GRP_DIV) ? KIND_DIV : KIND_MOD;
               end
            end
            GRP_MAX: res_in_nx = (x_w < a_w) ? a_w : x_w;
            GRP_MIN: res_in_nx = (a_w < x_w) ? a_w : x_w;
            default: begin
               if (x_w == '0) begin
                  res_in_nx = one_w;
               end else if (x_w[W-1]) begin
                  if (a_w == one_w) begin
                     res_in_nx = one_w;
                  end else if (a_w == ones_w) begin
                     res_in_nx = x_w[0] ? ones_w : one_w;
                  end else begin
                     res_in_nx = '0;
                  end
               end else begin
                  ctrl_in_nx.kind = KIND_POW;
                  res_in_nx       = one_w;
               end
            end
         endcase
      end
   end

   ctrl_type     ctrl0_ff;
   logic [W-1:0] quo0_ff, dvs0_ff, res0_ff, base0_ff, exp0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl0_ff <= '0;
      end else if (advance) begin
         ctrl0_ff <= ctrl_in_nx;
      end
      if (advance) begin
         quo0_ff  <= quo_in_nx;
         dvs0_ff  <= dvs_in_nx;
         res0_ff  <= res_in_nx;
         base0_ff <= base_in_nx;
         exp0_ff  <= exp_in_nx;
      end
   end

   assign ctrl_s[0] = ctrl0_ff;
   assign rem_s[0]  = '0;
   assign quo_s[0]  = quo0_ff;
   assign dvs_s[0]  = dvs0_ff;
   assign res_s[0]  = res0_ff;
   assign base_s[0] = base0_ff;
   assign exp_s[0]  = exp0_ff;

   for (genvar i = 0; i < W; i++) begin : g_step
      gnia_iter #(
         .W    (W),
         .STEP (i)
      ) u_iter (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .ctrl_in  (ctrl_s[i]),
         .rem_in   (rem_s[i]),
         .quo_in   (quo_s[i]),
         .dvs_in   (dvs_s[i]),
         .res_in   (res_s[i]),
         .base_in  (base_s[i]),
         .exp_in   (exp_s[i]),
         .ctrl_out (ctrl_s[i+1]),
         .rem_out  (rem_s[i+1]),
         .quo_out  (quo_s[i+1]),
         .dvs_out  (dvs_s[i+1]),
         .res_out  (res_s[i+1]),
         .base_out (base_s[i+1]),
         .exp_out  (exp_s[i+1])
      );
   end

   always_comb begin
      unique case (ctrl_s[W].kind)
         KIND_DIV: value_in = ctrl_s[W].neg_q ? W'(-quo_s[W]) : quo_s[W];
         KIND_MOD: value_in = ctrl_s[W].neg_r ? W'(-rem_s[W]) : rem_s[W];
         default:  value_in = res_s[W];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= ctrl_s[W].valid;
      end
      if (advance) begin
         value_ff  <= value_in;
         status_ff <= ctrl_s[W].status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_node_value = 32'(value_ff);
   assign rsp_status     = status_ff;

endmodule

// ===== hdl/gnia_checker.sv =====
// ----------------------------------------------------------------------------
// gnia_checker
// Port-level checks for the graph node integer ALU, bound to the top level.
// ----------------------------------------------------------------------------
module gnia_checker
   import gnia_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_node_value,
   input logic [1:0]  rsp_status
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_node_value)
                                 && $stable(rsp_status))
      else $error("response changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("undefined status code");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_DIV_ZERO || rsp_status == ST_BAD_OP)
      |-> rsp_node_value == 32'd0)
      else $error("error response carries a value");

   a_stall_follows: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled response");

   logic unused_valid;
   assign unused_valid = req_valid;

endmodule

bind graph_node_integer_alu gnia_checker u_gnia_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_node_value (rsp_node_value),
   .rsp_status     (rsp_status)
);
